// File: src/psc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psc_pkg;

  // field widths
  localparam int COEF_W      = 16;
  localparam int RAW_W       = 24;
  localparam int PRES_W      = 32;
  localparam int TEMP_W      = 19;
  localparam int REG_INDEX_W = 3;

  // register stages from input to output register
  localparam int NUM_STAGES = 10;

  // calibration words
  typedef struct packed {
    logic [COEF_W-1:0] sensitivity;
    logic [COEF_W-1:0] offset;
    logic [COEF_W-1:0] sensitivity_temp;
    logic [COEF_W-1:0] offset_temp;
    logic [COEF_W-1:0] reference_temp;
    logic [COEF_W-1:0] temperature;
  } coefs_t;

  localparam coefs_t COEFS_RESET = '{
    sensitivity:      16'd34982,
    offset:           16'd36352,
    sensitivity_temp: 16'd20328,
    offset_temp:      16'd22354,
    reference_temp:   16'd26646,
    temperature:      16'd26146
  };

  // configuration register indexes
  typedef enum logic [REG_INDEX_W-1:0] {
    REG_SENSITIVITY      = 3'd0,
    REG_OFFSET           = 3'd1,
    REG_SENSITIVITY_TEMP = 3'd2,
    REG_OFFSET_TEMP      = 3'd3,
    REG_REFERENCE_TEMP   = 3'd4,
    REG_TEMPERATURE      = 3'd5
  } reg_index_t;

  // temperature band constants, expressed on dtemp = temp - 2000
  localparam logic signed [19:0] TEMP_BASE   = 20'sd2000;
  localparam logic signed [19:0] VL_BIAS     = 20'sd3500;
  localparam logic signed [18:0] VLOW_DTEMP  = -19'sd3600;

  // output temperature clamp
  localparam logic signed [20:0] TEMP_MIN = -21'sd262144;
  localparam logic signed [20:0] TEMP_MAX = 21'sd262143;

endpackage

`default_nettype wire

// File: src/pressure_sensor_compensation.sv
// an accepted request is registered through every pipeline stage on its way to the output register
// throughput: one request per cycle while out_ready holds; every stage advances when the next one is empty or moving
// a stalled output holds its result while bubbles further up still fill
// reset (rst, synchronous): pipeline valid bits clear, calibration words return to defaults
`timescale 1ns / 1ps
`default_nettype none

module pressure_sensor_compensation (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [psc_pkg::REG_INDEX_W-1:0]        cfg_index,
  input  logic [psc_pkg::COEF_W-1:0]             cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [psc_pkg::RAW_W-1:0]              raw_pressure,
  input  logic [psc_pkg::RAW_W-1:0]              raw_temperature,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [psc_pkg::PRES_W-1:0]      pressure,
  output logic signed [psc_pkg::TEMP_W-1:0]      temperature
);

  psc_pkg::coefs_t coefs;

  psc_coef_regs u_coef_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  // pipeline control
  logic [psc_pkg::NUM_STAGES:1]   vld;
  logic [psc_pkg::NUM_STAGES:1]   vld_next;
  logic [psc_pkg::NUM_STAGES+1:1] adv;

  always_comb begin
    adv[psc_pkg::NUM_STAGES+1] = out_ready;
    for (int k = psc_pkg::NUM_STAGES; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
    vld_next[1] = adv[1] ? in_valid : vld[1];
    for (int k = 2; k <= psc_pkg::NUM_STAGES; k++) begin
      vld_next[k] = adv[k] ? vld[k-1] : vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign in_ready  = adv[1];
  assign out_valid = vld[psc_pkg::NUM_STAGES];

  // stage 1: dT
  logic [23:0]        s1_d1;
  logic signed [24:0] s1_dt;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_d1 <= raw_pressure;
      s1_dt <= signed'({1'b0, raw_temperature}) - signed'({1'b0, coefs.reference_temp, 8'h00});
    end
  end

  // stage 2: coefficient products and dT squared
  logic [23:0]        s2_d1;
  logic signed [41:0] s2_pc3;
  logic signed [41:0] s2_pc4;
  logic signed [41:0] s2_pc6;
  logic signed [49:0] s2_dt_sq;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_d1    <= s1_d1;
      s2_pc3   <= s1_dt * signed'({1'b0, coefs.sensitivity_temp});
      s2_pc4   <= s1_dt * signed'({1'b0, coefs.offset_temp});
      s2_pc6   <= s1_dt * signed'({1'b0, coefs.temperature});
      s2_dt_sq <= s1_dt * s1_dt;
    end
  end

  // stage 3: first-order sens, off, temp, band select and Ti
  logic signed [33:0] pc3_q;
  logic signed [34:0] pc4_q;
  logic signed [18:0] dtemp_c;
  logic signed [35:0] sens_c;
  logic signed [36:0] off_c;
  logic signed [19:0] temp_c;
  logic signed [19:0] vl_c;
  logic [49:0]        dsq3;
  logic [16:0]        ti_c;
  logic               low_c;
  logic               vlow_c;

  always_comb begin
    pc3_q   = 34'((s2_pc3 + (s2_pc3[41] ? 42'sd255 : 42'sd0)) >>> 8);
    pc4_q   = 35'((s2_pc4 + (s2_pc4[41] ? 42'sd127 : 42'sd0)) >>> 7);
    dtemp_c = 19'((s2_pc6 + (s2_pc6[41] ? 42'sd8388607 : 42'sd0)) >>> 23);
    sens_c  = signed'({5'd0, coefs.sensitivity, 15'd0}) + 36'(pc3_q);
    off_c   = signed'({5'd0, coefs.offset, 16'd0}) + 37'(pc4_q);
    temp_c  = 20'(dtemp_c) + psc_pkg::TEMP_BASE;
    vl_c    = 20'(dtemp_c) + psc_pkg::VL_BIAS;
    // temp/100 < 20 only when temp < 2000, temp/100 < -15 only when temp <= -1600
    low_c   = dtemp_c[18];
    vlow_c  = dtemp_c <= psc_pkg::VLOW_DTEMP;
    // dT squared is never negative, so the divisions are plain shifts
    dsq3    = {2'b00, s2_dt_sq[47:0]} + {1'b0, s2_dt_sq[47:0], 1'b0};
    ti_c    = low_c ? dsq3[49:33] : {5'd0, s2_dt_sq[47:36]};
  end

  logic [23:0]        s3_d1;
  logic signed [35:0] s3_sens;
  logic signed [36:0] s3_off;
  logic signed [18:0] s3_dtemp;
  logic signed [19:0] s3_temp;
  logic signed [19:0] s3_vl;
  logic [16:0]        s3_ti;
  logic               s3_low;
  logic               s3_vlow;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_d1    <= s2_d1;
      s3_sens  <= sens_c;
      s3_off   <= off_c;
      s3_dtemp <= dtemp_c;
      s3_temp  <= temp_c;
      s3_vl    <= vl_c;
      s3_ti    <= ti_c;
      s3_low   <= low_c;
      s3_vlow  <= vlow_c;
    end
  end

  // stage 4: temperature squares and corrected temperature
  logic [23:0]        s4_d1;
  logic signed [35:0] s4_sens;
  logic signed [36:0] s4_off;
  logic signed [37:0] s4_dsq;
  logic signed [39:0] s4_vsq;
  logic signed [20:0] s4_temp2;
  logic               s4_low;
  logic               s4_vlow;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_d1    <= s3_d1;
      s4_sens  <= s3_sens;
      s4_off   <= s3_off;
      s4_dsq   <= s3_dtemp * s3_dtemp;
      s4_vsq   <= s3_vl * s3_vl;
      s4_temp2 <= 21'(s3_temp) - signed'({4'd0, s3_ti});
      s4_low   <= s3_low;
      s4_vlow  <= s3_vlow;
    end
  end

  // stage 5: OFFi and SENSi by band
  logic [33:0] dsq;
  logic [34:0] vsq;
  logic [35:0] dsq3x;
  logic [36:0] dsq5x;
  logic [37:0] vsq7x;
  logic [38:0] offi_c;
  logic [37:0] sensi_c;

  always_comb begin
    dsq   = s4_dsq[33:0];
    vsq   = s4_vsq[34:0];
    dsq3x = {2'b00, dsq} + {1'b0, dsq, 1'b0};
    dsq5x = {3'b000, dsq} + {1'b0, dsq, 2'b00};
    vsq7x = {vsq, 3'b000} - {3'b000, vsq};
    if (s4_low) begin
      offi_c  = {4'd0, dsq3x[35:1]} + (s4_vlow ? {1'b0, vsq7x} : 39'd0);
      sensi_c = {4'd0, dsq5x[36:3]} + (s4_vlow ? {1'b0, vsq, 2'b00} : 38'd0);
    end else begin
      offi_c  = {9'd0, dsq[33:4]};
      sensi_c = '0;
    end
  end

  logic [23:0]        s5_d1;
  logic signed [35:0] s5_sens;
  logic signed [36:0] s5_off;
  logic [38:0]        s5_offi;
  logic [37:0]        s5_sensi;
  logic signed [20:0] s5_temp2;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_d1    <= s4_d1;
      s5_sens  <= s4_sens;
      s5_off   <= s4_off;
      s5_offi  <= offi_c;
      s5_sensi <= sensi_c;
      s5_temp2 <= s4_temp2;
    end
  end

  // stage 6: second-order off and sens
  logic [23:0]        s6_d1;
  logic signed [39:0] s6_off2;
  logic signed [38:0] s6_sens2;
  logic signed [20:0] s6_temp2;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_d1    <= s5_d1;
      s6_off2  <= 40'(s5_off) - signed'({1'b0, s5_offi});
      s6_sens2 <= 39'(s5_sens) - signed'({1'b0, s5_sensi});
      s6_temp2 <= s5_temp2;
    end
  end

  // stage 7: D1 * sens split into two partial products
  logic [43:0]        s7_pl;
  logic signed [43:0] s7_ph;
  logic signed [39:0] s7_off2;
  logic signed [20:0] s7_temp2;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_pl    <= s6_d1 * s6_sens2[19:0];
      s7_ph    <= signed'({1'b0, s6_d1}) * signed'(s6_sens2[38:20]);
      s7_off2  <= s6_off2;
      s7_temp2 <= s6_temp2;
    end
  end

  // stage 8: partial product sum
  logic signed [63:0] s8_prod;
  logic signed [39:0] s8_off2;
  logic signed [20:0] s8_temp2;

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      s8_prod  <= (64'(s7_ph) <<< 20) + signed'({20'd0, s7_pl});
      s8_off2  <= s7_off2;
      s8_temp2 <= s7_temp2;
    end
  end

  // stage 9: D1 * sens / 2^21 - off
  logic signed [42:0] prod_q;
  logic signed [43:0] s9_q;
  logic signed [20:0] s9_temp2;

  always_comb begin
    prod_q = 43'((s8_prod + (s8_prod[63] ? 64'sd2097151 : 64'sd0)) >>> 21);
  end

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      s9_q     <= 44'(prod_q) - 44'(s8_off2);
      s9_temp2 <= s8_temp2;
    end
  end

  // stage 10: final scaling and output clamp
  logic signed [30:0] p_q;
  logic signed [20:0] temp_sat;

  always_comb begin
    // the quotient always fits in 31 bits, so the 32-bit clamp is a plain extension
    p_q = 31'((s9_q + (s9_q[43] ? 44'sd8191 : 44'sd0)) >>> 13);
    if (s9_temp2 < psc_pkg::TEMP_MIN) begin
      temp_sat = psc_pkg::TEMP_MIN;
    end else if (s9_temp2 > psc_pkg::TEMP_MAX) begin
      temp_sat = psc_pkg::TEMP_MAX;
    end else begin
      temp_sat = s9_temp2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      pressure    <= 32'(p_q);
      temperature <= 19'(temp_sat);
    end
  end

endmodule

`default_nettype wire

// File: src/psc_coef_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module psc_coef_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [psc_pkg::REG_INDEX_W-1:0]    cfg_index,
  input  logic [psc_pkg::COEF_W-1:0]         cfg_data,
  output psc_pkg::coefs_t                    coefs
);

  // calibration word bank, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      coefs <= psc_pkg::COEFS_RESET;
    end else if (cfg_write) begin
      case (psc_pkg::reg_index_t'(cfg_index))
        psc_pkg::REG_SENSITIVITY:      coefs.sensitivity      <= cfg_data;
        psc_pkg::REG_OFFSET:           coefs.offset           <= cfg_data;
        psc_pkg::REG_SENSITIVITY_TEMP: coefs.sensitivity_temp <= cfg_data;
        psc_pkg::REG_OFFSET_TEMP:      coefs.offset_temp      <= cfg_data;
        psc_pkg::REG_REFERENCE_TEMP:   coefs.reference_temp   <= cfg_data;
        psc_pkg::REG_TEMPERATURE:      coefs.temperature      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/psc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module psc_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [psc_pkg::PRES_W-1:0]    pressure,
  input logic signed [psc_pkg::TEMP_W-1:0]    temperature
);

  // reset empties the pipeline
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // a free or draining output never blocks the input
  assert property (@(posedge clk) disable iff (rst)
    (out_ready || !out_valid) |-> in_ready)
    else $error("input stalled while output can move");

  // with the output always taken, an accepted request shows up as a valid result once it has passed every stage
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
    ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
    |=> out_valid)
    else $error("result missing after pipeline latency");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(pressure) && $stable(temperature)))
    else $error("stalled result changed");

endmodule

bind pressure_sensor_compensation psc_checker u_psc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .pressure    (pressure),
  .temperature (temperature)
);

`default_nettype wire
